// ===== sv/ppc_pkg.sv =====
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types and constants for the per-peer packet counter.
// ----------------------------------------------------------------------------
package ppc_pkg;

	localparam int unsigned ADDR_W    = 32;
	localparam int unsigned ETYPE_W   = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [ETYPE_W-1:0] ETHERTYPE_IPV4 = 16'h0800;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OWN_IP      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXCLUDED_IP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_IP  = 2'd2;

	// register reset values
	localparam logic [ADDR_W-1:0] OWN_IP_RST      = 32'h0000_0000;
	localparam logic [ADDR_W-1:0] EXCLUDED_IP_RST = 32'hD3FC_5178;
	localparam logic [ADDR_W-1:0] GATEWAY_IP_RST  = 32'hC0A8_0001;

	// lookup request toward the peer table
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] key;
	} lookup_req_t;

	// lookup answer, valid in the same cycle as the request
	typedef struct packed {
		logic              counted;
		logic              full;
		logic [ADDR_W-1:0] count;
	} lookup_rsp_t;

endpackage

// ===== sv/ppc_table.sv =====
// ----------------------------------------------------------------------------
// ppc_table
// Associative peer table: parallel key match, saturating count update and
// in-order allocation of new entries.
// ----------------------------------------------------------------------------
module ppc_table #(
	parameter int unsigned TABLE_ENTRIES = 64,
	parameter int unsigned COUNT_BITS    = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ppc_pkg::lookup_req_t req,
	input  logic                 probe,
	input  logic [31:0]          probe_key,
	output ppc_pkg::lookup_rsp_t rsp
);
	import ppc_pkg::*;

	localparam int unsigned USED_W = $clog2(TABLE_ENTRIES + 1);
	localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [USED_W-1:0] USED_MAX = USED_W'(TABLE_ENTRIES);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [ADDR_W-1:0]     key_q [TABLE_ENTRIES];
	logic [COUNT_BITS-1:0] cnt_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] vld_q;
	logic [USED_W-1:0]     used_q;

	logic [TABLE_ENTRIES-1:0] match;
	logic [COUNT_BITS-1:0]    hit_cnt;
	logic [COUNT_BITS-1:0]    inc_cnt;
	logic [COUNT_BITS+31:0]   inc_ext;
	logic                     hit;
	logic                     full;
	logic                     alloc;
	logic [IDX_W-1:0]         alloc_idx;

	// per-entry compare, one-hot select of the hit count
	always_comb begin
		hit_cnt = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			match[i] = vld_q[i] && (key_q[i] == req.key);
			if (match[i]) begin
				hit_cnt = hit_cnt | cnt_q[i];
			end
		end
	end

	assign hit       = |match;
	assign full      = (used_q == USED_MAX);
	assign alloc     = req.en && !hit && !full;
	assign alloc_idx = used_q[IDX_W-1:0];
	assign inc_cnt   = (hit_cnt == CNT_MAX) ? hit_cnt : hit_cnt + COUNT_BITS'(1);
	assign inc_ext   = {32'd0, inc_cnt};

	always_comb begin
		rsp.counted = hit || !full;
		rsp.full    = !hit && full;
		if (!hit) begin
			rsp.count = full ? '0 : 32'd1;
		end else if (|inc_ext[COUNT_BITS+31:32]) begin
			rsp.count = '1;
		end else begin
			rsp.count = inc_ext[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			used_q <= '0;
		end else if (alloc) begin
			vld_q[alloc_idx] <= 1'b1;
			used_q           <= used_q + USED_W'(1);
		end
	end

	// entry payload, no reset
	always_ff @(posedge clk) begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (req.en && match[i]) begin
				cnt_q[i] <= inc_cnt;
			end else if (alloc && (alloc_idx == IDX_W'(i))) begin
				key_q[i] <= req.key;
				cnt_q[i] <= COUNT_BITS'(1);
			end
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_MAX)
		else $error("table fill count beyond table size");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("peer key stored in more than one entry");

	a_probe_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		alloc |=> (vld_q != $past(vld_q)))
		else $error("allocation did not mark a new entry valid");

	a_probe_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(probe && req.en && (probe_key == req.key) && !full) |=>
		(|(vld_q & ~$past(vld_q))) || $past(hit))
		else $error("eligible peer neither hit nor allocated");

endmodule

// ===== sv/per_peer_packet_counter.sv =====
// ----------------------------------------------------------------------------
// per_peer_packet_counter
// Counts packets per IPv4 peer of a monitored host in an associative table.
// ----------------------------------------------------------------------------
// path: an accepted input beat goes through the input register, then the result register
// throughput: one beat per cycle while the result stream is not stalled; match,
//   increment and table write for an item all happen in the cycle it leaves the input register
// reset: arst_n clears the table valid bits, fill count, packet total and
//   both pipeline valids; config registers return to their defaults
module per_peer_packet_counter #(
	parameter int unsigned TABLE_ENTRIES = 64,
	parameter int unsigned COUNT_BITS    = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input header stream
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [15:0] frame_type, [47:16] src_addr, [79:48] dst_addr
	input  logic [79:0]                   s_axis_tdata,
	// result stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [31:0] peer_addr, [63:32] peer_count, [95:64] total_packets
	output logic [95:0]                   m_axis_tdata,
	// [0] counted, [1] table_full
	output logic [1:0]                    m_axis_tuser,
	// config write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ppc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import ppc_pkg::*;

	// config registers
	logic [ADDR_W-1:0] own_ip_q;
	logic [ADDR_W-1:0] excluded_ip_q;
	logic [ADDR_W-1:0] gateway_ip_q;

	// input register stage
	logic               valid_s1;
	logic [ETYPE_W-1:0] etype_s1;
	logic [ADDR_W-1:0]  src_s1;
	logic [ADDR_W-1:0]  dst_s1;

	// result register stage
	logic              valid_s2;
	logic              counted_s2;
	logic              full_s2;
	logic [ADDR_W-1:0] peer_s2;
	logic [ADDR_W-1:0] count_s2;
	logic [ADDR_W-1:0] total_q;

	logic              advance;
	logic              take_in;
	logic [ADDR_W-1:0] peer;
	logic              eligible;
	lookup_req_t       req;
	lookup_rsp_t       rsp;

	// config writes are registered directly, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q      <= OWN_IP_RST;
			excluded_ip_q <= EXCLUDED_IP_RST;
			gateway_ip_q  <= GATEWAY_IP_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_OWN_IP:      own_ip_q      <= cfg_data;
				REG_EXCLUDED_IP: excluded_ip_q <= cfg_data;
				REG_GATEWAY_IP:  gateway_ip_q  <= cfg_data;
				default: ;  // unknown index, write dropped
			endcase
		end
	end

	// s1 moves to s2 whenever the result slot is free or being drained
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			etype_s1 <= s_axis_tdata[15:0];
			src_s1   <= s_axis_tdata[47:16];
			dst_s1   <= s_axis_tdata[79:48];
		end
	end

	// peer is the far side as seen from the monitored host
	assign peer = (src_s1 == own_ip_q) ? dst_s1 : src_s1;

	// filter: ipv4 only, no self traffic, no excluded host, no gateway
	assign eligible = (etype_s1 == ETHERTYPE_IPV4) && (src_s1 != dst_s1) &&
		(src_s1 != excluded_ip_q) && (dst_s1 != excluded_ip_q) &&
		(peer != gateway_ip_q);

	assign req.en  = advance && eligible;
	assign req.key = peer;

	ppc_table #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.COUNT_BITS    (COUNT_BITS)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.probe     (advance),
		.probe_key (peer),
		.rsp       (rsp)
	);

	// result register and running total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			total_q  <= '0;
		end else begin
			if (advance) begin
				valid_s2 <= 1'b1;
				if (total_q != '1) begin
					total_q <= total_q + 32'd1;
				end
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			counted_s2 <= eligible && rsp.counted;
			full_s2    <= eligible && rsp.full;
			peer_s2    <= (eligible && rsp.counted) ? peer : '0;
			count_s2   <= (eligible && rsp.counted) ? rsp.count : '0;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {total_q, count_s2, peer_s2};
	assign m_axis_tuser  = {full_s2, counted_s2};

	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (total_q != '1)) |=> (total_q == $past(total_q) + 32'd1))
		else $error("packet total did not advance");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(counted_s2 && full_s2))
		else $error("result both counted and table full");

	a_dropped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !counted_s2) |-> ((peer_s2 == '0) && (count_s2 == '0)))
		else $error("dropped packet carries peer data");

	a_counted_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && counted_s2) |-> (count_s2 != '0))
		else $error("counted peer with zero count");

endmodule

// ===== tb/per_peer_packet_counter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_peer_packet_counter_tb
// Drives packet headers into the per-peer packet counter, keeps its own
// model of the peer table and filters, and checks every result beat field
// by field. Covers filter rules, every register setting, table fill and
// overflow, and random traffic under random idling and long backpressure.
// ----------------------------------------------------------------------------
module per_peer_packet_counter_tb;

	import ppc_pkg::*;

	localparam int unsigned TABLE_ENTRIES = 64;
	localparam int unsigned COUNT_BITS    = 32;
	localparam int unsigned POOL_SIZE     = 48;
	// settle time after the last result before touching registers
	localparam int unsigned SETTLE_CYCLES = 4;
	// index beyond the register file, the block must ignore it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// one expected result beat
	typedef struct {
		logic              counted;
		logic [ADDR_W-1:0] peer;
		logic [31:0]       count;
		logic              full;
		logic [31:0]       total;
	} tally_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	// [15:0] frame_type, [47:16] src_addr, [79:48] dst_addr
	logic [79:0]          s_axis_tdata  = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	// [31:0] peer_addr, [63:32] peer_count, [95:64] total_packets
	logic [95:0]          m_axis_tdata;
	// [0] counted, [1] table_full
	logic [1:0]           m_axis_tuser;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [31:0]          cfg_data      = '0;

	// model copy of the filter registers
	logic [ADDR_W-1:0] host_ip;
	logic [ADDR_W-1:0] blocked_ip;
	logic [ADDR_W-1:0] gateway_addr;

	// model copy of the peer table and running total
	logic [ADDR_W-1:0] known_peer [TABLE_ENTRIES];
	logic [31:0]       peer_hits  [TABLE_ENTRIES];
	logic              slot_live  [TABLE_ENTRIES];
	int unsigned       slots_used;
	logic [31:0]       packets_seen;

	tally_t            pending_tallies [$];
	logic [ADDR_W-1:0] peer_pool [POOL_SIZE];

	int unsigned mismatch_count = 0;
	// idling controls for the sender and the result sink
	bit          tx_no_idle  = 1'b0;
	bit          rx_no_idle  = 1'b0;
	int unsigned rx_hold_req = 0;

	per_peer_packet_counter #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.COUNT_BITS   (COUNT_BITS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("per_peer_packet_counter verification failed");
		$finish;
	end

	function automatic int unsigned draw_gap(bit no_idle);
		if (no_idle)
			return 0;
		return $urandom_range(0, 8);
	endfunction

	// table slot holding addr, or -1
	function automatic int find_slot(logic [ADDR_W-1:0] addr);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (slot_live[i] && known_peer[i] == addr)
				return i;
		return -1;
	endfunction

	// what the block must report for one accepted header, updating the model table
	function automatic tally_t tally_packet(logic [ETYPE_W-1:0] etype, logic [ADDR_W-1:0] src,
			logic [ADDR_W-1:0] dst);
		tally_t           t;
		logic [ADDR_W-1:0] peer;
		int               slot;
		t = '{counted: 1'b0, peer: '0, count: '0, full: 1'b0, total: '0};
		if (packets_seen != '1)
			packets_seen++;
		t.total = packets_seen;
		// the peer is the far end when the host itself sends
		peer = (src == host_ip) ? dst : src;
		if (etype == ETHERTYPE_IPV4 && src != dst && src != blocked_ip && dst != blocked_ip
				&& peer != gateway_addr) begin
			slot = find_slot(peer);
			if (slot >= 0) begin
				if (peer_hits[slot] != '1)
					peer_hits[slot]++;
				t.counted = 1'b1;
				t.peer    = peer;
				t.count   = peer_hits[slot];
			end else if (slots_used < TABLE_ENTRIES) begin
				known_peer[slots_used] = peer;
				peer_hits[slots_used]  = 32'd1;
				slot_live[slots_used]  = 1'b1;
				slots_used++;
				t.counted = 1'b1;
				t.peer    = peer;
				t.count   = 32'd1;
			end else begin
				t.full = 1'b1;
			end
		end
		return t;
	endfunction

	// one header beat, with a random gap in front
	task automatic send_header(logic [ETYPE_W-1:0] etype, logic [ADDR_W-1:0] src,
			logic [ADDR_W-1:0] dst);
		int unsigned gap;
		gap = draw_gap(tx_no_idle);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {dst, src, etype};
		do @(posedge clk); while (!s_axis_tready);
		pending_tallies.push_back(tally_packet(etype, src, dst));
	endtask

	// sender stops and waits for every outstanding result
	task automatic quiesce();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_tallies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_OWN_IP:      host_ip      = value;
			REG_EXCLUDED_IP: blocked_ip   = value;
			REG_GATEWAY_IP:  gateway_addr = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_filters(logic [31:0] own, logic [31:0] excl, logic [31:0] gw);
		quiesce();
		write_register(REG_OWN_IP, own);
		write_register(REG_EXCLUDED_IP, excl);
		write_register(REG_GATEWAY_IP, gw);
	endtask

	// random header, mostly well-formed host traffic with some of every filter case
	function automatic void make_header(output logic [ETYPE_W-1:0] etype,
			output logic [ADDR_W-1:0] src, output logic [ADDR_W-1:0] dst);
		int unsigned      pick;
		logic [ADDR_W-1:0] far_end;
		pick    = $urandom_range(0, 99);
		far_end = peer_pool[$urandom_range(0, POOL_SIZE - 1)];
		etype   = ETHERTYPE_IPV4;
		src     = host_ip;
		dst     = far_end;
		if (pick < 25) begin
			// inbound from a known peer
			src = far_end;
			dst = host_ip;
		end else if (pick < 32) begin
			// traffic between two other hosts
			src = far_end;
			dst = peer_pool[$urandom_range(0, POOL_SIZE - 1)];
		end else if (pick < 38) begin
			dst = $urandom;
		end else if (pick < 44) begin
			etype = ETYPE_W'($urandom_range(0, 16'hFFFF));
		end else if (pick < 48) begin
			if ($urandom_range(0, 1))
				src = blocked_ip;
			else
				dst = blocked_ip;
		end else if (pick < 52) begin
			if ($urandom_range(0, 1)) begin
				dst = gateway_addr;
			end else begin
				src = gateway_addr;
				dst = far_end;
			end
		end else if (pick < 56) begin
			src = far_end;
			dst = far_end;
		end else if (pick < 60) begin
			if ($urandom_range(0, 1))
				etype = ETYPE_W'($urandom_range(0, 16'hFFFF));
			src = $urandom;
			dst = $urandom;
		end
	endfunction

	task automatic run_traffic(int unsigned beats);
		logic [ETYPE_W-1:0] etype;
		logic [ADDR_W-1:0]  src;
		logic [ADDR_W-1:0]  dst;
		repeat (beats) begin
			make_header(etype, src, dst);
			send_header(etype, src, dst);
		end
	endtask

	// filter rules and table hits under the reset register values
	task automatic test_reset_defaults();
		send_header(ETHERTYPE_IPV4, 32'h0000_0000, 32'h0A00_0001);
		send_header(ETHERTYPE_IPV4, 32'h0000_0000, 32'h0A00_0001);
		// source side is the peer when the host is not the sender
		send_header(ETHERTYPE_IPV4, 32'h0A00_0001, 32'h0A00_0002);
		send_header(ETHERTYPE_IPV4, 32'hFFFF_FFFF, 32'h0000_0000);
		send_header(ETHERTYPE_IPV4, 32'h0000_0000, 32'hFFFF_FFFF);
		// same address on both sides
		send_header(ETHERTYPE_IPV4, 32'h0000_0000, 32'h0000_0000);
		send_header(ETHERTYPE_IPV4, 32'h0A00_0003, 32'h0A00_0003);
		// not ipv4
		send_header(16'hFFFF, 32'h0000_0000, 32'h0A00_0001);
		send_header(16'h0000, 32'h0000_0000, 32'h0A00_0001);
		send_header(16'h0801, 32'h0000_0000, 32'h0A00_0001);
		// excluded address on either side
		send_header(ETHERTYPE_IPV4, EXCLUDED_IP_RST, 32'h0000_0000);
		send_header(ETHERTYPE_IPV4, 32'h0000_0000, EXCLUDED_IP_RST);
		// gateway chosen as peer from either direction
		send_header(ETHERTYPE_IPV4, 32'h0000_0000, GATEWAY_IP_RST);
		send_header(ETHERTYPE_IPV4, GATEWAY_IP_RST, 32'h0B00_0001);
		// gateway as destination of a third party is fine
		send_header(ETHERTYPE_IPV4, 32'h0B00_0001, GATEWAY_IP_RST);
		send_header(ETHERTYPE_IPV4, 32'h0000_0000, $urandom);
	endtask

	// every register written, out-of-range index ignored
	task automatic test_register_writes();
		quiesce();
		write_register(REG_UNUSED, 32'hFFFF_FFFF);
		write_register(REG_OWN_IP, 32'hFFFF_FFFF);
		write_register(REG_EXCLUDED_IP, 32'h0000_0000);
		write_register(REG_GATEWAY_IP, 32'hFFFF_FFFF);
		send_header(ETHERTYPE_IPV4, 32'hFFFF_FFFF, 32'h0A00_0001);
		send_header(ETHERTYPE_IPV4, 32'h0A00_0001, 32'hFFFF_FFFF);
		send_header(ETHERTYPE_IPV4, 32'h0000_0000, 32'h0A00_0001);
		send_header(ETHERTYPE_IPV4, 32'h0A00_0005, 32'h0000_0000);
		// old reset gateway is an ordinary peer now
		send_header(ETHERTYPE_IPV4, 32'hFFFF_FFFF, GATEWAY_IP_RST);
		send_header(ETHERTYPE_IPV4, 32'h0C00_0001, 32'h0A00_0001);
	endtask

	// random traffic across several filter settings, extremes included
	task automatic test_random_traffic();
		set_filters($urandom, 32'h0000_0000, 32'hFFFF_FFFF);
		run_traffic(120);
		set_filters(32'hFFFF_FFFF, $urandom, 32'h0000_0000);
		// a stretch with no idling on either side
		tx_no_idle = 1'b1;
		rx_no_idle = 1'b1;
		run_traffic(60);
		tx_no_idle = 1'b0;
		rx_no_idle = 1'b0;
		run_traffic(60);
		set_filters(32'h0000_0000, 32'hFFFF_FFFF, $urandom);
		run_traffic(120);
	endtask

	// sink holds off while the sender keeps offering back to back beats
	task automatic test_backpressure();
		quiesce();
		rx_hold_req = 80;
		tx_no_idle  = 1'b1;
		run_traffic(40);
		tx_no_idle  = 1'b0;
		// sender pauses until every result is back
		quiesce();
	endtask

	// fill the table, then overflow it with new peers and revisit old ones
	task automatic test_table_full();
		logic [ADDR_W-1:0] fresh;
		set_filters($urandom, $urandom, $urandom);
		while (slots_used < TABLE_ENTRIES) begin
			fresh = $urandom;
			if (fresh != host_ip && fresh != blocked_ip && fresh != gateway_addr
					&& find_slot(fresh) < 0)
				send_header(ETHERTYPE_IPV4, host_ip, fresh);
		end
		repeat (12) send_header(ETHERTYPE_IPV4, $urandom, host_ip);
		repeat (12) send_header(ETHERTYPE_IPV4, host_ip,
				known_peer[$urandom_range(0, TABLE_ENTRIES - 1)]);
	endtask

	// random traffic with a full table: hits on old peers, drops on new ones
	task automatic test_random_after_full();
		for (int i = 0; i < POOL_SIZE; i += 2)
			peer_pool[i] = known_peer[$urandom_range(0, TABLE_ENTRIES - 1)];
		set_filters($urandom, $urandom, $urandom);
		run_traffic(330);
	endtask

	// result sink: random stall before each beat, plus long holds on request
	initial begin : result_sink
		int unsigned stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (rx_hold_req != 0) begin
				stall       = rx_hold_req;
				rx_hold_req = 0;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
			end
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				stall = draw_gap(rx_no_idle);
		end
	end

	// compare every accepted result beat with the oldest expectation
	always @(posedge clk) begin : check_result
		tally_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_tallies.size() == 0) begin
				$error("result beat with no packet outstanding");
				mismatch_count++;
			end else begin
				want = pending_tallies.pop_front();
				if (m_axis_tuser[0] !== want.counted) begin
					$error("counted: expected %0b, got %0b", want.counted, m_axis_tuser[0]);
					mismatch_count++;
				end
				if (m_axis_tdata[31:0] !== want.peer) begin
					$error("peer_addr: expected %h, got %h", want.peer, m_axis_tdata[31:0]);
					mismatch_count++;
				end
				if (m_axis_tdata[63:32] !== want.count) begin
					$error("peer_count: expected %0d, got %0d", want.count,
							m_axis_tdata[63:32]);
					mismatch_count++;
				end
				if (m_axis_tuser[1] !== want.full) begin
					$error("table_full: expected %0b, got %0b", want.full, m_axis_tuser[1]);
					mismatch_count++;
				end
				if (m_axis_tdata[95:64] !== want.total) begin
					$error("total_packets: expected %0d, got %0d", want.total,
							m_axis_tdata[95:64]);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		host_ip      = OWN_IP_RST;
		blocked_ip   = EXCLUDED_IP_RST;
		gateway_addr = GATEWAY_IP_RST;
		slots_used   = 0;
		packets_seen = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			slot_live[i] = 1'b0;
		for (int i = 0; i < POOL_SIZE; i++)
			peer_pool[i] = $urandom;

		// hold reset, then release it between edges
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_register_writes();
		test_random_traffic();
		test_backpressure();
		test_table_full();
		test_random_after_full();

		quiesce();
		if (pending_tallies.size() != 0) begin
			$error("%0d results never arrived", pending_tallies.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("per_peer_packet_counter verification clean");
		else
			$display("per_peer_packet_counter verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/ppc_pkg.sv
sv/ppc_table.sv
sv/per_peer_packet_counter.sv
tb/per_peer_packet_counter_tb.sv
